/* hw/rtl/smps_pkg.sv */
package smps_pkg;

  // palette and sine table geometry
  localparam int PALETTE_SIZE = 256;
  localparam int PAL_AW       = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam int SINE_STEPS   = 4096;
  localparam int SINE_AW      = $clog2(SINE_STEPS);
  localparam int QTR_STEPS    = SINE_STEPS / 4;
  localparam int QTR_AW       = $clog2(QTR_STEPS + 1);

  // field widths
  localparam int PIX_W   = 12;
  localparam int SLOT_W  = 8;
  localparam int COLOR_W = 24;
  localparam int CFG_W   = 24;

  // arithmetic unit widths
  localparam int DIV_N_W  = 28;
  localparam int DIV_D_W  = 16;
  localparam int ROOT_W   = 17;
  localparam int ISQ_IN_W = 2 * ROOT_W;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_RENDER = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_FRAME_NUMBER = 2'd2,
    CFG_PATTERN_SEED = 2'd3
  } cfg_reg_e;

  // taylor divisors (2k)(2k+1)
  typedef longint unsigned taylor_t [9];
  localparam taylor_t TAYLOR_DIV = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                     64'd156, 64'd210, 64'd272, 64'd342};

  typedef logic [13:0] qsine_tab_t [QTR_STEPS + 1];

  function automatic logic [13:0] quarter_sine(longint unsigned i);
    longint unsigned th;
    longint unsigned th2;
    longint unsigned term;
    longint unsigned sum;
    th   = (i * 64'd6746518852 + 64'd2048) >> 12;
    th2  = (th * th) >> 30;
    term = th;
    sum  = th;
    for (int k = 1; k <= 9; k++) begin
      term = (term * th2) >> 30;
      term = term / TAYLOR_DIV[k-1];
      if ((k % 2) == 1) sum = sum - term;
      else sum = sum + term;
    end
    return 14'((sum * 64'd16383 + (64'd1 << 29)) >> 30);
  endfunction

  function automatic qsine_tab_t build_qsine();
    qsine_tab_t tab;
    for (int i = 0; i <= QTR_STEPS; i++) begin
      tab[i] = quarter_sine(longint'(i));
    end
    tab[0] = '0;
    return tab;
  endfunction

  localparam qsine_tab_t QSINE = build_qsine();

  // full-turn q14 sine from the quarter-wave table
  function automatic logic signed [14:0] sine_at(logic [SINE_AW-1:0] idx);
    logic [SINE_AW-2:0] j;
    logic [SINE_AW-2:0] k;
    logic signed [14:0] mag;
    j   = idx[SINE_AW-2:0];
    k   = (j > (SINE_AW-1)'(QTR_STEPS)) ? (SINE_AW-1)'(2 * QTR_STEPS - int'(j)) : j;
    mag = $signed({1'b0, QSINE[k[QTR_AW-1:0]]});
    return idx[SINE_AW-1] ? -mag : mag;
  endfunction

endpackage

/* hw/rtl/smps_in_if.sv */
interface smps_in_if;
  import smps_pkg::*;
  logic               valid;
  logic               ready;
  logic               command;
  logic [PIX_W-1:0]   pixel_x;
  logic [PIX_W-1:0]   pixel_y;
  logic [SLOT_W-1:0]  palette_slot;
  logic [COLOR_W-1:0] palette_color;

  modport source (output valid, command, pixel_x, pixel_y, palette_slot, palette_color,
                  input ready);
  modport sink (input valid, command, pixel_x, pixel_y, palette_slot, palette_color,
                output ready);
endinterface

/* hw/rtl/smps_out_if.sv */
interface smps_out_if;
  import smps_pkg::*;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel_color;

  modport source (output valid, pixel_color, input ready);
  modport sink (input valid, pixel_color, output ready);
endinterface

/* hw/rtl/smps_ram.sv */
module smps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

/* hw/rtl/smps_isqrt.sv */
module smps_isqrt (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [smps_pkg::ISQ_IN_W-1:0] rad_i,
  output logic [smps_pkg::ROOT_W-1:0]   root_o
);
  import smps_pkg::*;

  localparam int LAST = ROOT_W - 1;

  logic [ROOT_W+1:0]   rem_q  [LAST];
  logic [ISQ_IN_W-1:0] rad_q  [LAST];
  logic [ROOT_W-1:0]   root_q [ROOT_W];

  // one root bit per stage
  for (genvar s = 0; s < ROOT_W; s++) begin : g_st
    logic [ROOT_W+1:0]   rem_in;
    logic [ISQ_IN_W-1:0] rad_in;
    logic [ROOT_W-1:0]   root_in;
    logic [ROOT_W+3:0]   r_ext;
    logic [ROOT_W+3:0]   trial;
    logic                fits;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign rad_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign root_in = root_q[s-1];
    end

    assign r_ext = {rem_in, rad_in[ISQ_IN_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign fits  = (r_ext >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[s] <= {root_in[ROOT_W-2:0], fits};
      end
    end

    if (s < LAST) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= fits ? (ROOT_W+2)'(r_ext - trial) : (ROOT_W+2)'(r_ext);
          rad_q[s] <= rad_in << 2;
        end
      end
    end
  end

  assign root_o = root_q[LAST];
endmodule

/* hw/rtl/smps_div.sv */
module smps_div (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [smps_pkg::DIV_N_W-1:0] dividend_i,
  input  logic [smps_pkg::DIV_D_W-1:0] divisor_i,
  output logic [smps_pkg::DIV_N_W-1:0] quotient_o
);
  import smps_pkg::*;

  localparam int LAST = DIV_N_W - 1;

  logic [DIV_D_W-1:0] rem_q [LAST];
  logic [DIV_D_W-1:0] den_q [LAST];
  logic [DIV_N_W-1:0] dq_q  [DIV_N_W];

  // restoring division, one quotient bit per stage
  for (genvar s = 0; s < DIV_N_W; s++) begin : g_st
    logic [DIV_D_W-1:0] rem_in;
    logic [DIV_D_W-1:0] den_in;
    logic [DIV_N_W-1:0] dq_in;
    logic [DIV_D_W:0]   r_ext;
    logic               fits;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign den_in = divisor_i;
      assign dq_in  = dividend_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign dq_in  = dq_q[s-1];
    end

    assign r_ext = {rem_in, dq_in[DIV_N_W-1]};
    assign fits  = (r_ext >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dq_q[s] <= {dq_in[DIV_N_W-2:0], fits};
      end
    end

    if (s < LAST) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= fits ? DIV_D_W'(r_ext - {1'b0, den_in}) : DIV_D_W'(r_ext);
          den_q[s] <= den_in;
        end
      end
    end
  end

  assign quotient_o = dq_q[LAST];
endmodule

/* hw/rtl/spoke_moire_pixel_shader.sv */
// Spoke moire pixel shader: one pixel per clock unless stalled, fully pipelined. Each
// word on item_i is either a palette write (command 0) or a render request (command 1);
// a render word comes out on result_o, palette writes give no word. The depth is set
// by the 17-stage square root feeding the 28-stage radius dividers (the angle divider
// runs beside it). The whole pipeline freezes while a finished pixel waits on result_o,
// so nothing is lost or repeated. Palette writes are done in stream order at the palette
// read stage, so a render word sees exactly the writes that came before it. The sine
// table is a constant quarter-wave rom; there is no clearing pass after reset.
// Configuration must be written only while idle; the block does not enforce this.
module spoke_moire_pixel_shader (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  smps_pkg::cfg_reg_e  cfg_index_i,
  input  logic [smps_pkg::CFG_W-1:0] cfg_data_i,
  smps_in_if.sink             item_i,
  smps_out_if.source          result_o
);
  import smps_pkg::*;

  // stage numbers, counted in registers after the input register
  localparam int ST_FRONT = 1;
  localparam int ST_SQ    = 2;
  localparam int ST_ROOT  = ST_SQ + ROOT_W;
  localparam int ST_PROD  = ST_ROOT + 1;
  localparam int ST_RING  = ST_PROD + DIV_N_W;
  localparam int ST_QUO   = ST_FRONT + DIV_N_W;
  localparam int ST_T     = ST_QUO + 1;
  localparam int ST_M     = ST_T + 3;
  localparam int ST_AI    = ST_M + 1;
  localparam int ST_IDX   = ST_RING + 1;
  localparam int ST_SINE  = ST_IDX + 1;
  localparam int ST_OUT   = ST_SINE + 4;
  localparam int N_ST     = ST_OUT + 1;
  localparam int AI_N     = ST_SINE - ST_AI + 1;

  localparam int RPROD_W = ROOT_W + 24;
  localparam logic [PAL_AW-1:0] PAL_MASK = PAL_AW'(PALETTE_SIZE - 1);
  localparam int SLOT_EXT_W = (PAL_AW > SLOT_W) ? PAL_AW : SLOT_W;

  typedef struct packed {
    cmd_e               cmd;
    logic [SLOT_W-1:0]  slot;
    logic [COLOR_W-1:0] color;
    logic               dx_neg;
    logic               dy_neg;
    logic               num_neg;
    logic               center;
  } side_t;

  // configuration registers
  logic [12:0] width_q, height_q;
  logic [23:0] frame_q;
  logic [14:0] seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd320;
      height_q <= 13'd240;
      frame_q  <= '0;
      seed_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[12:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[12:0];
        CFG_FRAME_NUMBER: frame_q  <= cfg_data_i[23:0];
        CFG_PATTERN_SEED: seed_q   <= cfg_data_i[14:0];
      endcase
    end
  end

  // frame phases and palette drift, registered from the configuration registers
  logic [SINE_AW-1:0] ph1_q, ph2_q, phr_q;
  logic [PAL_AW-1:0]  drift_q;

  always_ff @(posedge clk_i) begin
    ph1_q   <= SINE_AW'((43'(frame_q) * 43'd341783) >> 16);
    ph2_q   <= SINE_AW'((43'(frame_q) * 43'd290515) >> 16);
    phr_q   <= SINE_AW'((45'(frame_q) * 45'd1196239) >> 16);
    // frame * 3 / 5 by reciprocal, exact for 24-bit frames
    drift_q <= PAL_AW'(((52'(frame_q) * 52'd161061276) >> 28) + 52'(seed_q));
  end

  // pipeline advance: everything moves unless a finished pixel is held
  logic adv;
  logic [N_ST-1:0] valid_q;
  side_t side_q [N_ST];
  side_t side_front;

  assign result_o.valid = valid_q[ST_OUT] && (side_q[ST_OUT].cmd == CMD_RENDER);
  assign adv            = !result_o.valid || result_o.ready;
  assign item_i.ready   = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[N_ST-2:0], item_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= '{cmd: cmd_e'(item_i.command), slot: item_i.palette_slot,
                     color: item_i.palette_color, dx_neg: 1'b0, dy_neg: 1'b0,
                     num_neg: 1'b0, center: 1'b0};
      side_q[ST_FRONT] <= side_front;
      for (int k = ST_FRONT + 1; k < N_ST; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // input word register
  logic [PIX_W-1:0] x0_q, y0_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x0_q <= item_i.pixel_x;
      y0_q <= item_i.pixel_y;
    end
  end

  // doubled centre offsets, magnitudes and the atan ratio operands
  logic signed [14:0] dx, dy, num;
  logic [13:0] ax, ay;
  logic [13:0] ax1_q, ay1_q, nummag1_q;
  logic [14:0] den1_q;

  always_comb begin
    dx  = $signed({2'b00, x0_q, 1'b0}) - $signed({2'b00, width_q});
    dy  = $signed({2'b00, y0_q, 1'b0}) - $signed({2'b00, height_q});
    ax  = 14'(dx[14] ? -dx : dx);
    ay  = 14'(dy[14] ? -dy : dy);
    num = dx[14] ? $signed({1'b0, ay}) - $signed({1'b0, ax})
                 : $signed({1'b0, ax}) - $signed({1'b0, ay});
    side_front         = side_q[0];
    side_front.dx_neg  = dx[14];
    side_front.dy_neg  = dy[14];
    side_front.num_neg = num[14];
    side_front.center  = (ax == '0) && (ay == '0);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax1_q     <= ax;
      ay1_q     <= ay;
      nummag1_q <= 14'(num[14] ? -num : num);
      den1_q    <= {1'b0, ax} + {1'b0, ay};
    end
  end

  // squared radius, then the radius in q.4
  logic [26:0] sq2_q;
  logic [ROOT_W-1:0] r4;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq2_q <= 27'(28'(ax1_q) * 28'(ax1_q) + 28'(ay1_q) * 28'(ay1_q));
    end
  end

  smps_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (ISQ_IN_W'({sq2_q, 6'b0})),
    .root_o (r4)
  );

  // angle ratio divide, magnitude only
  logic [DIV_N_W-1:0] atan_quo;

  smps_div u_div_atan (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i ({nummag1_q, 14'b0}),
    .divisor_i  (DIV_D_W'(den1_q)),
    .quotient_o (atan_quo)
  );

  // spiral and ring radius scaling: r4 * k / (w * 4096)
  logic [DIV_N_W-1:0] rp1_q, rp2_q, rpk_q;
  logic [DIV_N_W-1:0] ri1_quo, ri2_quo, rk_quo;
  logic [DIV_D_W-1:0] wdiv;

  assign wdiv = DIV_D_W'((width_q == '0) ? 13'd1 : width_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rp1_q <= DIV_N_W'((RPROD_W'(r4) * RPROD_W'(1068071)) >> 12);
      rp2_q <= DIV_N_W'((RPROD_W'(r4) * RPROD_W'(854457)) >> 12);
      rpk_q <= DIV_N_W'((RPROD_W'(r4) * RPROD_W'(8544566)) >> 12);
    end
  end

  smps_div u_div_ri1 (
    .clk_i(clk_i), .en_i(adv), .dividend_i(rp1_q), .divisor_i(wdiv), .quotient_o(ri1_quo)
  );
  smps_div u_div_ri2 (
    .clk_i(clk_i), .en_i(adv), .dividend_i(rp2_q), .divisor_i(wdiv), .quotient_o(ri2_quo)
  );
  smps_div u_div_rk (
    .clk_i(clk_i), .en_i(adv), .dividend_i(rpk_q), .divisor_i(wdiv), .quotient_o(rk_quo)
  );

  // atan polynomial: signed ratio, t^2, t^3, then the angle index
  logic signed [15:0] t_q, t2_q, tc2_q, t3_q, tc3_q;
  logic signed [33:0] m_q;
  logic signed [15:0] t_d;
  logic signed [21:0] ang;
  logic [SINE_AW-1:0] ai_q [AI_N];

  always_comb begin
    if (side_q[ST_QUO].center) begin
      // centre pixel: ratio taken as -1
      t_d = -16'sd16384;
    end else if (side_q[ST_QUO].num_neg) begin
      t_d = -$signed({1'b0, atan_quo[14:0]});
    end else begin
      t_d = $signed({1'b0, atan_quo[14:0]});
    end
    ang = 22'(m_q >>> 14) + (side_q[ST_M].dx_neg ? 22'sd393216 : 22'sd131072);
    if (side_q[ST_M].dy_neg) begin
      ang = -ang;
    end
    ang = ang + 22'sd128;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_q   <= t_d;
      t2_q  <= 16'((32'(t_q) * 32'(t_q)) >>> 14);
      tc2_q <= t_q;
      t3_q  <= 16'((32'(t2_q) * 32'(tc2_q)) >>> 14);
      tc3_q <= tc2_q;
      m_q   <= 34'sd32760 * 34'(t3_q) - 34'sd163832 * 34'(tc3_q);
      ai_q[0] <= ang[19:8];
      for (int k = 1; k < AI_N; k++) begin
        ai_q[k] <= ai_q[k-1];
      end
    end
  end

  // sine indices and lookups
  logic [SINE_AW-1:0] ai_idx;
  logic [SINE_AW-1:0] i1_q, i2_q, i3_q;
  logic signed [14:0] g1_q, g2_q, ring_q;

  assign ai_idx = ai_q[ST_RING - ST_AI];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      i1_q <= SINE_AW'(32'(ai_idx) * 32'd9 + 32'(ri1_quo[SINE_AW-1:0]) + 32'(ph1_q));
      i2_q <= SINE_AW'(32'd0 - 32'(ai_idx) * 32'd11 - 32'(ri2_quo[SINE_AW-1:0])
                     - 32'(ph2_q));
      i3_q <= rk_quo[SINE_AW-1:0] - phr_q;
      g1_q   <= sine_at(i1_q);
      g2_q   <= sine_at(i2_q);
      ring_q <= sine_at(i3_q);
    end
  end

  // mix terms and palette access
  logic signed [15:0] fsum;
  logic signed [29:0] ring_b, ring_p;
  logic signed [16:0] a_q;
  logic signed [15:0] b_q;
  logic [PAL_AW-1:0]  pal_raddr, pal_waddr;
  logic [SLOT_EXT_W-1:0] slot_ext;
  logic [COLOR_W-1:0] pal_rdata;
  logic               pal_we;

  always_comb begin
    fsum      = (16'(g1_q) + 16'(g2_q)) >>> 1;
    ring_b    = (30'(ring_q) * 30'sd7373) >>> 14;
    ring_p    = (30'(ring_q) * 30'sd3277) >>> 14;
    pal_raddr = (drift_q + PAL_AW'({ai_q[ST_SINE - ST_AI], 3'b000}) + PAL_AW'(ring_p))
                & PAL_MASK;
    slot_ext  = SLOT_EXT_W'(side_q[ST_SINE].slot);
    pal_waddr = PAL_AW'(slot_ext) & PAL_MASK;
    pal_we    = adv && valid_q[ST_SINE] && (side_q[ST_SINE].cmd == CMD_WRITE);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q <= 17'sd8192 + 17'(fsum >>> 1);
      b_q <= 16'sd9011 + 16'(ring_b);
    end
  end

  smps_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_SIZE)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (pal_waddr),
    .wdata_i (side_q[ST_SINE].color),
    .re_i    (adv),
    .raddr_i (pal_raddr),
    .rdata_o (pal_rdata)
  );

  // brightness and channel scaling
  logic signed [33:0] ab;
  logic [13:0] p_q;
  logic [14:0] vv;
  logic [7:0]  v8_q;
  logic [COLOR_W-1:0] c1_q, c2_q, out_q;

  always_comb begin
    ab = (34'(a_q) * 34'(b_q)) >>> 14;
    vv = 15'd2458 + 15'((28'(p_q) * 28'd13926) >> 14);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q   <= (ab > 34'sd16383) ? 14'd16383 : 14'(ab);
      c1_q  <= pal_rdata;
      v8_q  <= vv[13:6];
      c2_q  <= c1_q;
      out_q <= {8'((16'(c2_q[23:16]) * 16'(v8_q)) >> 8),
                8'((16'(c2_q[15:8]) * 16'(v8_q)) >> 8),
                8'((16'(c2_q[7:0]) * 16'(v8_q)) >> 8)};
    end
  end

  assign result_o.pixel_color = out_q;

  // checks
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.ready |-> !item_i.ready)
    else $error("input taken while a pixel is held");

  a_center_ratio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[ST_QUO] && side_q[ST_QUO].center && adv |=> t_q == -16'sd16384)
    else $error("centre pixel ratio not forced");

  a_valid_travels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[ST_OUT] && $past(adv) |-> $past(valid_q[ST_OUT-1]))
    else $error("output valid without a word behind it");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pal_we |=> !(valid_q[ST_SINE+1] && side_q[ST_SINE+1].cmd == CMD_RENDER))
    else $error("palette write turned into a render word");
endmodule

/* dv/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import smps_pkg::*;

  localparam int HOLD_CYCLES  = 500;   // long receiver hold-off
  localparam int WDOG_LIMIT   = 4000;  // cycles with no word accepted on either side
  localparam int DRAIN_CYCLES = 80;    // drain time, longer than the whole pipeline
  localparam int PHASE_WORDS  = 175;

  typedef struct packed {
    cmd_e               cmd;
    logic [PIX_W-1:0]   x;
    logic [PIX_W-1:0]   y;
    logic [SLOT_W-1:0]  slot;
    logic [COLOR_W-1:0] color;
  } shader_word_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  cfg_reg_e cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;

  smps_in_if  item_if ();
  smps_out_if result_if ();

  spoke_moire_pixel_shader u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_if.sink),
    .result_o    (result_if.source)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // shadow of the shader state
  logic signed [15:0] sine_rom [SINE_STEPS];
  logic [COLOR_W-1:0] pal_shadow [PALETTE_SIZE];
  bit                 pal_written [PALETTE_SIZE];
  longint             img_w, img_h, frame_cnt, seed;

  shader_word_t       pending_words[$];
  logic [COLOR_W-1:0] expected_pixels[$];

  int  err_count;
  int  send_idle_pct, recv_stall_pct;
  bit  hold_recv;
  int  phase_no;

  // taylor series sine of i/4096 turn in q14, i up to a quarter turn
  function automatic int qsine(longint unsigned i);
    longint unsigned th, th2, term, sum;
    th   = (i * 64'd6746518852 + 64'd2048) / 64'd4096;
    th2  = (th * th) >> 30;
    term = th;
    sum  = th;
    for (int k = 1; k <= 9; k++) begin
      term = (term * th2) >> 30;
      term = term / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    return int'((sum * 64'd16383 + (64'd1 << 29)) >> 30);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // 12-bit angle from the polynomial atan2 approximation
  function automatic longint polar_angle(longint dx, longint dy);
    longint ay, t, t2, t3, a;
    ay = (dy < 0) ? -dy : dy;
    if (dx >= 0) t = (dx + ay == 0) ? -16384 : ((dx - ay) * 16384) / (dx + ay);
    else t = ((dx + ay) * 16384) / (ay - dx);
    t2 = (t * t) >>> 14;
    t3 = (t2 * t) >>> 14;
    a  = ((32760 * t3 - 163832 * t) >>> 14) + ((dx >= 0) ? 131072 : 393216);
    if (dy < 0) a = -a;
    return ((a + 2097280) >>> 8) & 4095;
  endfunction

  // shaded colour of one pixel plus the palette entry it reads
  function automatic void shade_pixel(input longint px, input longint py,
                                      output int pal_idx, output logic [COLOR_W-1:0] rgb);
    longint dx, dy, ai, ri1, ri2, rk, p1, p2, pr, drift, f, amp, bias, prod, v, v8;
    longint g1, g2, ring;
    longint unsigned r4, wd;
    logic [COLOR_W-1:0] c;
    dx  = 2 * px - img_w;
    dy  = 2 * py - img_h;
    r4  = int_sqrt(longint'(dx * dx + dy * dy) * 64);
    ai  = polar_angle(dx, dy);
    wd  = ((img_w == 0) ? 1 : img_w) * 4096;
    ri1 = longint'((r4 * 64'd1068071) / wd);
    ri2 = longint'((r4 * 64'd854457) / wd);
    rk  = longint'((r4 * 64'd8544566) / wd);
    p1  = (frame_cnt * 341783) >> 16;
    p2  = (frame_cnt * 290515) >> 16;
    pr  = (frame_cnt * 1196239) >> 16;
    drift = (frame_cnt * 3) / 5 + seed;
    g1   = sine_rom[(9 * ai + ri1 + p1) & 4095];
    g2   = sine_rom[(-11 * ai - ri2 - p2) & 4095];
    ring = sine_rom[(rk - pr) & 4095];
    f    = (g1 + g2) >>> 1;
    amp  = 8192 + (f >>> 1);
    bias = 9011 + ((ring * 7373) >>> 14);
    prod = (amp * bias) >>> 14;
    if (prod > 16383) prod = 16383;
    v  = 2458 + ((prod * 13926) >>> 14);
    v8 = (v >>> 6) & 1023;
    pal_idx = int'((drift + ai * 8 + ((ring * 3277) >>> 14)) & (PALETTE_SIZE - 1));
    c = pal_shadow[pal_idx];
    rgb[23:16] = 8'((longint'(c[23:16]) * v8) >> 8);
    rgb[15:8]  = 8'((longint'(c[15:8]) * v8) >> 8);
    rgb[7:0]   = 8'((longint'(c[7:0]) * v8) >> 8);
  endfunction

  function automatic void queue_write(logic [SLOT_W-1:0] slot, logic [COLOR_W-1:0] color);
    shader_word_t w;
    w = '{cmd: CMD_WRITE, x: 12'($urandom), y: 12'($urandom), slot: slot, color: color};
    pal_shadow[slot & (PALETTE_SIZE - 1)]  = color;
    pal_written[slot & (PALETTE_SIZE - 1)] = 1'b1;
    pending_words.push_back(w);
  endfunction

  // render a pixel; an unwritten palette entry gets filled first
  function automatic void queue_render(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
    shader_word_t w;
    int idx;
    logic [COLOR_W-1:0] rgb;
    shade_pixel(longint'(x), longint'(y), idx, rgb);
    if (!pal_written[idx]) begin
      queue_write(SLOT_W'(idx), 24'($urandom));
      shade_pixel(longint'(x), longint'(y), idx, rgb);
    end
    w = '{cmd: CMD_RENDER, x: x, y: y, slot: 8'($urandom), color: 24'($urandom)};
    pending_words.push_back(w);
    expected_pixels.push_back(rgb);
  endfunction

  task automatic write_reg(cfg_reg_e idx, longint value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_W'(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:  img_w     = value & 13'h1fff;
      CFG_IMAGE_HEIGHT: img_h     = value & 13'h1fff;
      CFG_FRAME_NUMBER: frame_cnt = value & 24'hffffff;
      default:          seed      = value & 15'h7fff;
    endcase
  endtask

  // block is idle: nothing queued, nothing outstanding, tail of writes flushed
  task automatic wait_idle();
    while (pending_words.size() != 0 || expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [PIX_W-1:0] rand_coord(longint extent);
    if ($urandom_range(0, 1) == 0 || extent < 1) return PIX_W'($urandom);
    return PIX_W'($urandom_range(0, int'((extent > 4096) ? 4095 : extent - 1)));
  endfunction

  // sender: hold the word until taken, then maybe idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_if.valid         <= 1'b0;
      item_if.command       <= CMD_WRITE;
      item_if.pixel_x       <= '0;
      item_if.pixel_y       <= '0;
      item_if.palette_slot  <= '0;
      item_if.palette_color <= '0;
    end else if (!(item_if.valid && !item_if.ready)) begin
      if (item_if.valid && item_if.ready) void'(pending_words.pop_front());
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        item_if.valid         <= 1'b1;
        item_if.command       <= pending_words[0].cmd;
        item_if.pixel_x       <= pending_words[0].x;
        item_if.pixel_y       <= pending_words[0].y;
        item_if.palette_slot  <= pending_words[0].slot;
        item_if.palette_color <= pending_words[0].color;
      end else begin
        item_if.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus the long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= !hold_recv && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // checker: each pixel against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (expected_pixels.size() == 0) begin
        $error("pixel_color: unexpected word, actual %06h", result_if.pixel_color);
        err_count++;
      end else begin
        if (result_if.pixel_color !== expected_pixels[0]) begin
          $error("pixel_color: expected %06h actual %06h", expected_pixels[0],
                 result_if.pixel_color);
          err_count++;
        end
        void'(expected_pixels.pop_front());
      end
    end
  end

  // watchdog on stuck handshakes
  int stuck_cycles;
  always @(posedge clk_i) begin
    if (!rst_ni || (item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // long receiver hold-off in the pressure phase, sender keeps offering
  initial begin
    hold_recv = 1'b0;
    wait (phase_no == 4);
    @(posedge clk_i);
    hold_recv <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_recv <= 1'b0;
  end

  initial begin
    longint cfg_set [8][4];
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = CFG_IMAGE_WIDTH;
    cfg_data_i     = '0;
    err_count      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    phase_no       = 0;
    img_w = 320; img_h = 240; frame_cnt = 0; seed = 0;
    for (int i = 0; i < PALETTE_SIZE; i++) begin
      pal_shadow[i]  = '0;
      pal_written[i] = 1'b0;
    end
    for (int i = 0; i <= SINE_STEPS / 4; i++) begin
      sine_rom[i]                        = 16'(qsine(i));
      sine_rom[SINE_STEPS / 2 - i]       = 16'(qsine(i));
      sine_rom[(SINE_STEPS / 2 + i) % SINE_STEPS] = -16'(qsine(i));
      sine_rom[(SINE_STEPS - i) % SINE_STEPS]     = -16'(qsine(i));
    end
    sine_rom[0]              = '0;
    sine_rom[SINE_STEPS / 2] = '0;

    // width, height, frame, seed per phase; phase 0 runs on reset values
    cfg_set = '{'{320, 240, 0, 0}, '{1, 1, 24'hffffff, 15'h7fff},
                '{4096, 4096, 12345, 100}, '{0, 240, 777, 5},
                '{640, 480, 0, 0}, '{17, 4096, 24'h800000, 15'h4000},
                '{0, 0, 0, 0}, '{4096, 1, 0, 0}};
    cfg_set[6] = '{$urandom_range(1, 4096), $urandom_range(1, 4096),
                   $urandom_range(0, 24'hffffff), $urandom_range(0, 15'h7fff)};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: palette extremes, centre pixel, frame corners
    queue_write(8'hff, 24'hffffff);
    queue_write(8'h00, 24'h000000);
    queue_write(8'haa, 24'h55aa55);
    queue_write(8'h55, 24'haa55aa);
    queue_render(12'd160, 12'd120);
    queue_render(12'd0, 12'd0);
    queue_render(12'd4095, 12'd4095);
    queue_render(12'd4095, 12'd0);
    queue_render(12'd0, 12'd4095);
    queue_render(12'd319, 12'd239);
    queue_render(12'd160, 12'd0);
    queue_render(12'd0, 12'd120);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph != 0) begin
        // sender pauses until every pixel is back, then reconfigure
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, cfg_set[ph][0]);
        write_reg(CFG_IMAGE_HEIGHT, cfg_set[ph][1]);
        write_reg(CFG_FRAME_NUMBER, cfg_set[ph][2]);
        write_reg(CFG_PATTERN_SEED, cfg_set[ph][3]);
        // centre pixel of the new frame when it has one
        if (img_w % 2 == 0 && img_h % 2 == 0 && img_w <= 8190 && img_h <= 8190)
          queue_render(PIX_W'(img_w / 2), PIX_W'(img_h / 2));
      end
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      phase_no = ph;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 3) == 0) queue_write(8'($urandom), 24'($urandom));
        else queue_render(rand_coord(img_w), rand_coord(img_h));
      end
    end

    wait_idle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
